@@ hw/rtl/sensor_packet_deframer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Sensor packet deframer assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_DEFRAMER_TOP_MACROS_SVH
`define SENSOR_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTH
// Checked on every clk edge outside reset.
`define SPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clk edge outside reset whose previous edge was also outside reset.
`define SPD_ASSERT_POST_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> (prop)) \
    else $error(msg);
`else
`define SPD_ASSERT(lbl, prop, msg)
`define SPD_ASSERT_POST_RST(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Shared constants, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int RECORD_BYTES = 3;

  localparam logic [7:0] START_MARKER_RST = 8'hFA;

  typedef enum logic [2:0] {
    ST_RECORD     = 3'd0,
    ST_EMPTY_OK   = 3'd1,
    ST_BAD_MARKER = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CAPTURE,
    S_EMIT
  } state_t;

endpackage

@@ hw/rtl/spd_buf.sv @@
// ----------------------------------------------------------------------------
// Sensor packet deframer byte buffer
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module spd_buf #(
  parameter int Depth = spd_pkg::BUFFER_BYTES,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/sensor_packet_deframer_top.sv @@
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Buffers one radio packet, checks marker, length and XOR checksum on the
// last byte, then emits one result per record or one status result.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------
//  in_     | input     | in_valid/stall   | data_byte, last_byte, signal_strength
//  out_    | output    | out_valid/stall  | status, record_strength,
//          |           |                  | record_byte0..2, final_result
//  cfg_    | input     | cfg_wr_en        | cfg_wr_data (start marker)
//
//  Sequencing: a non-last byte and a failing or empty packet are taken while
//  the sequencer stays idle. A good packet stalls the input for a record walk:
//  per record, K = min(RecordBytes, 3) bytes come through the single read port
//  of the buffer, one read/capture pair each, then S_EMIT loads the output.
//  Reset: synchronous, active low; clears counters, sequencer and output
//  valid, and restores the start marker to 0xFA. The buffer itself is not
//  cleared; entries are only read after being written in the same packet.
//  Stalls: results sit in one output register. The input is stalled during
//  a record walk and whenever a result waits under out_stall, so every byte,
//  last or not, needs a free output slot to transfer.
//
// ----------------------------------------------------------------------------
`include "sensor_packet_deframer_top_macros.svh"

module sensor_packet_deframer_top #(
  parameter int BufferBytes = spd_pkg::BUFFER_BYTES,
  parameter int RecordBytes = spd_pkg::RECORD_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic signed [7:0] in_signal_strength,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic signed [7:0] out_record_strength,
  output logic [7:0]        out_record_byte0,
  output logic [7:0]        out_record_byte1,
  output logic [7:0]        out_record_byte2,
  output logic              out_final_result,

  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  // Address width of the buffer, count width able to hold BufferBytes itself.
  localparam int AW   = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;
  localparam int CW   = $clog2(BufferBytes + 1);
  // Width of count*RecordBytes + 2 for any count byte.
  localparam int NW   = 8 + $clog2(RecordBytes + 1) + 1;
  // Record bytes that reach the output.
  localparam int Keep = (RecordBytes < 3) ? RecordBytes : 3;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  spd_pkg::state_t  state_r, state_nxt;

  logic [7:0]       start_marker_r, start_marker_nxt;
  logic [CW-1:0]    byte_count_r, byte_count_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;
  logic             overflowed_r, overflowed_nxt;
  // Copies of the first two bytes so the checks need no buffer read.
  logic [7:0]       marker_byte_r, marker_byte_nxt;
  logic [7:0]       count_byte_r, count_byte_nxt;

  // Record walk
  logic [7:0]       rec_left_r, rec_left_nxt;
  logic [CW-1:0]    base_r, base_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [7:0]       rec_r [3];
  logic [7:0]       rec_nxt [3];
  logic signed [7:0] strength_r, strength_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  spd_pkg::status_t out_status_r, out_status_nxt;
  logic signed [7:0] out_strength_r, out_strength_nxt;
  logic [7:0]       out_b0_r, out_b0_nxt;
  logic [7:0]       out_b1_r, out_b1_nxt;
  logic [7:0]       out_b2_r, out_b2_nxt;
  logic             out_final_r, out_final_nxt;

  // --------------------------------------------------------------------------
  // Buffer
  // --------------------------------------------------------------------------
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [CW-1:0]    rd_ptr;
  logic [7:0]       rd_data;

  spd_buf #(
    .Depth (BufferBytes)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic out_free;
  logic in_xfer;
  logic has_room;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == spd_pkg::S_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign has_room = byte_count_r < CW'(BufferBytes);

  assign wr_en   = in_xfer && !in_last_byte && has_room;
  assign wr_addr = byte_count_r[AW-1:0];
  assign rd_ptr  = base_r + CW'(pos_r);
  assign rd_en   = (state_r == spd_pkg::S_READ);

  // --------------------------------------------------------------------------
  // Packet check on the last byte. Order matters: overflow, marker, length,
  // checksum, then empty versus records.
  // --------------------------------------------------------------------------
  logic [NW-1:0]    need_len;
  spd_pkg::status_t pkt_status;

  assign need_len = NW'(count_byte_r) * NW'(RecordBytes) + NW'(2);

  always_comb begin
    priority if (overflowed_r) begin
      pkt_status = spd_pkg::ST_OVERFLOW;
    end else if (byte_count_r == '0 || marker_byte_r != start_marker_r) begin
      pkt_status = spd_pkg::ST_BAD_MARKER;
    end else if (byte_count_r < CW'(2)) begin
      pkt_status = spd_pkg::ST_BAD_LENGTH;
    end else if (need_len != NW'(byte_count_r)) begin
      pkt_status = spd_pkg::ST_BAD_LENGTH;
    end else if (running_xor_r != in_data_byte) begin
      pkt_status = spd_pkg::ST_BAD_SUM;
    end else if (count_byte_r == '0) begin
      pkt_status = spd_pkg::ST_EMPTY_OK;
    end else begin
      pkt_status = spd_pkg::ST_RECORD;
    end
  end

  logic walk_start;
  assign walk_start = in_xfer && in_last_byte && (pkt_status == spd_pkg::ST_RECORD);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spd_pkg::S_IDLE: begin
        if (walk_start) begin
          state_nxt = spd_pkg::S_READ;
        end
      end
      spd_pkg::S_READ: begin
        state_nxt = spd_pkg::S_CAPTURE;
      end
      spd_pkg::S_CAPTURE: begin
        if (pos_r == 2'(Keep - 1)) begin
          state_nxt = spd_pkg::S_EMIT;
        end else begin
          state_nxt = spd_pkg::S_READ;
        end
      end
      spd_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = (rec_left_r == 8'd1) ? spd_pkg::S_IDLE : spd_pkg::S_READ;
        end
      end
      default: state_nxt = spd_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    start_marker_nxt = cfg_wr_en ? cfg_wr_data : start_marker_r;
    byte_count_nxt   = byte_count_r;
    running_xor_nxt  = running_xor_r;
    overflowed_nxt   = overflowed_r;
    marker_byte_nxt  = marker_byte_r;
    count_byte_nxt   = count_byte_r;
    rec_left_nxt     = rec_left_r;
    base_nxt         = base_r;
    pos_nxt          = pos_r;
    rec_nxt          = rec_r;
    strength_nxt     = strength_r;

    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_strength_nxt = out_strength_r;
    out_b0_nxt       = out_b0_r;
    out_b1_nxt       = out_b1_r;
    out_b2_nxt       = out_b2_r;
    out_final_nxt    = out_final_r;

    unique case (state_r)
      spd_pkg::S_IDLE: begin
        if (in_xfer && !in_last_byte) begin
          if (has_room) begin
            byte_count_nxt = byte_count_r + CW'(1);
            if (byte_count_r == CW'(0)) begin
              marker_byte_nxt = in_data_byte;
            end
            if (byte_count_r == CW'(1)) begin
              count_byte_nxt = in_data_byte;
            end
          end else begin
            overflowed_nxt = 1'b1;
          end
          running_xor_nxt = running_xor_r ^ in_data_byte;
        end else if (in_xfer) begin
          // Last byte: the packet is settled, counters clear for the next.
          byte_count_nxt  = '0;
          running_xor_nxt = '0;
          overflowed_nxt  = 1'b0;
          if (walk_start) begin
            rec_left_nxt = count_byte_r;
            base_nxt     = CW'(2);
            pos_nxt      = '0;
            strength_nxt = in_signal_strength;
            for (int k = 0; k < 3; k++) begin
              rec_nxt[k] = '0;
            end
          end else begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = pkt_status;
            out_strength_nxt = '0;
            out_b0_nxt       = '0;
            out_b1_nxt       = '0;
            out_b2_nxt       = '0;
            out_final_nxt    = 1'b1;
          end
        end
      end
      spd_pkg::S_READ: begin
        // read issued at rd_ptr
      end
      spd_pkg::S_CAPTURE: begin
        rec_nxt[pos_r] = rd_data;
        if (pos_r != 2'(Keep - 1)) begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      spd_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = spd_pkg::ST_RECORD;
          out_strength_nxt = strength_r;
          out_b0_nxt       = rec_r[0];
          out_b1_nxt       = rec_r[1];
          out_b2_nxt       = rec_r[2];
          out_final_nxt    = (rec_left_r == 8'd1);
          rec_left_nxt     = rec_left_r - 8'd1;
          base_nxt         = base_r + CW'(RecordBytes);
          pos_nxt          = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= spd_pkg::S_IDLE;
      start_marker_r <= spd_pkg::START_MARKER_RST;
      byte_count_r   <= '0;
      running_xor_r  <= '0;
      overflowed_r   <= 1'b0;
      rec_left_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      start_marker_r <= start_marker_nxt;
      byte_count_r   <= byte_count_nxt;
      running_xor_r  <= running_xor_nxt;
      overflowed_r   <= overflowed_nxt;
      rec_left_r     <= rec_left_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    marker_byte_r  <= marker_byte_nxt;
    count_byte_r   <= count_byte_nxt;
    base_r         <= base_nxt;
    pos_r          <= pos_nxt;
    rec_r          <= rec_nxt;
    strength_r     <= strength_nxt;
    out_status_r   <= out_status_nxt;
    out_strength_r <= out_strength_nxt;
    out_b0_r       <= out_b0_nxt;
    out_b1_r       <= out_b1_nxt;
    out_b2_r       <= out_b2_nxt;
    out_final_r    <= out_final_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_record_strength = out_strength_r;
  assign out_record_byte0    = out_b0_r;
  assign out_record_byte1    = out_b1_r;
  assign out_record_byte2    = out_b2_r;
  assign out_final_result    = out_final_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPD_ASSERT(a_count_bound, byte_count_r <= CW'(BufferBytes), "byte count past buffer size")
  `SPD_ASSERT(a_walk_has_records, state_r != spd_pkg::S_IDLE |-> rec_left_r != 8'd0, "record walk with no records left")
  `SPD_ASSERT(a_more_records, out_valid && !out_stall && out_status_r == spd_pkg::ST_RECORD && !out_final_r |-> state_r != spd_pkg::S_IDLE, "non-final record transfer with walk finished")
  `SPD_ASSERT_POST_RST(a_walk_in_buffer, state_r == spd_pkg::S_READ |-> rd_ptr < CW'(BufferBytes), "record read past buffer")

endmodule

@@ tb/sensor_packet_deframer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Sensor packet deframer testbench
// Streams framed and malformed packets byte by byte through the deframer,
// predicts every record and status result in a local deframing model, and
// compares each result transfer field by field under random idling on both
// sides, a long output hold-off and start marker changes between phases.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_top_tb;

  localparam int HOLD_CYCLES   = 300;     // long output hold-off
  localparam int SETTLE_CYCLES = 8;       // quiet time before a marker write
  localparam int END_CYCLES    = 200;     // watch for stray results at the end
  localparam int PHASE_BYTES   = 6;       // random bytes per phase

  // One byte as it crosses the input channel.
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic signed [7:0] rssi;
  } rx_byte_t;

  // One deframed result as it leaves on the output channel.
  typedef struct packed {
    spd_pkg::status_t  status;
    logic signed [7:0] rssi;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic              fin;
  } deframed_t;

  // Shapes of packet the stimulus can build.
  typedef enum int {
    PK_GOOD,
    PK_BAD_MARKER,
    PK_BAD_SUM,
    PK_SHORT,
    PK_LONG,
    PK_LONE_LAST,
    PK_MARKER_ONLY,
    PK_OVERFLOW,
    PK_NOISE
  } pkt_kind_t;

  logic              clk;
  logic              rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic signed [7:0] in_signal_strength = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_status;
  logic signed [7:0] out_record_strength;
  logic [7:0]        out_record_byte0;
  logic [7:0]        out_record_byte1;
  logic [7:0]        out_record_byte2;
  logic              out_final_result;

  logic              cfg_wr_en = 1'b0;
  logic [7:0]        cfg_wr_data = '0;

  sensor_packet_deframer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .in_signal_strength  (in_signal_strength),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_record_strength (out_record_strength),
    .out_record_byte0    (out_record_byte0),
    .out_record_byte1    (out_record_byte1),
    .out_record_byte2    (out_record_byte2),
    .out_final_result    (out_final_result),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Deframing model: mirrors the packet buffer, byte count, running XOR and
  // overflow flag, plus the start marker register.
  // --------------------------------------------------------------------------
  logic [7:0] pkt_buf [spd_pkg::BUFFER_BYTES];
  int         pkt_len = 0;
  logic [7:0] pkt_xor = '0;
  bit         pkt_ovf = 1'b0;
  logic [7:0] marker  = spd_pkg::START_MARKER_RST;

  rx_byte_t  rx_bytes_q[$];     // bytes waiting to be offered to the block
  deframed_t deframed_q[$];     // results the block still owes us

  int bytes_queued  = 0;
  int bytes_sent    = 0;
  int n_bad         = 0;
  int phase_no      = 0;
  int tx_calm       = 0;
  int rx_calm       = 0;
  bit rx_hold       = 1'b0;
  int rx_stall_left = 0;

  // Fold one accepted byte into the model; a last byte resolves the packet.
  function automatic void deframe_byte(input rx_byte_t it);
    spd_pkg::status_t st;
    int               cnt;
    int               i;
    deframed_t        r;
    if (!it.last) begin
      // non-last bytes never produce a result; past the buffer end they
      // only mark the packet as overflowed but still feed the XOR
      if (pkt_len < spd_pkg::BUFFER_BYTES) begin
        pkt_buf[pkt_len] = it.data;
        pkt_len++;
      end else begin
        pkt_ovf = 1'b1;
      end
      pkt_xor ^= it.data;
      return;
    end
    r     = '0;
    r.fin = 1'b1;
    cnt   = 0;
    // check order: overflow, marker, length, checksum
    if (pkt_ovf) st = spd_pkg::ST_OVERFLOW;
    else if (pkt_len < 1 || pkt_buf[0] != marker) st = spd_pkg::ST_BAD_MARKER;
    else if (pkt_len < 2) st = spd_pkg::ST_BAD_LENGTH;
    else begin
      cnt = pkt_buf[1];
      if (cnt * spd_pkg::RECORD_BYTES + 2 != pkt_len) st = spd_pkg::ST_BAD_LENGTH;
      else if (pkt_xor != it.data) st = spd_pkg::ST_BAD_SUM;
      else if (cnt == 0) st = spd_pkg::ST_EMPTY_OK;
      else st = spd_pkg::ST_RECORD;
    end
    if (st == spd_pkg::ST_RECORD) begin
      for (i = 0; i < cnt; i++) begin
        r.status = spd_pkg::ST_RECORD;
        r.rssi   = it.rssi;
        r.b0     = pkt_buf[2 + i * spd_pkg::RECORD_BYTES];
        r.b1     = pkt_buf[3 + i * spd_pkg::RECORD_BYTES];
        r.b2     = pkt_buf[4 + i * spd_pkg::RECORD_BYTES];
        r.fin    = (i == cnt - 1);
        deframed_q.push_back(r);
      end
    end else begin
      r.status = st;
      deframed_q.push_back(r);
    end
    pkt_len = 0;
    pkt_xor = '0;
    pkt_ovf = 1'b0;
  endfunction

  // Idle gap before the next transfer, drawn at random, with runs of zero now and then.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input driver: pops bytes from rx_bytes_q, holds each until its transfer,
  // then waits a random gap. The model sees each byte at its transfer edge.
  // --------------------------------------------------------------------------
  rx_byte_t tx_cur;
  int       tx_gap = 0;

  always @(posedge clk) begin : tx_drive
    int w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      w = -1;                           // -1: payload held, nothing to do
      if (in_valid && !in_stall) begin
        deframe_byte(tx_cur);
        bytes_sent++;
        w = draw_wait(tx_calm);
      end else if (!in_valid) begin
        w = tx_gap;
      end
      if (w == 0 && rx_bytes_q.size() != 0) begin
        tx_cur = rx_bytes_q.pop_front();
        in_valid           <= 1'b1;
        in_data_byte       <= tx_cur.data;
        in_last_byte       <= tx_cur.last;
        in_signal_strength <= tx_cur.rssi;
        tx_gap             <= 0;
      end else if (w >= 0) begin
        in_valid <= 1'b0;
        tx_gap   <= (w > 0) ? w - 1 : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks every result transfer against the oldest
  // prediction, then stalls for a random number of cycles. rx_hold forces
  // a long stall from its own process.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_check
    deframed_t exp;
    int        nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      nxt = 0;
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result: st=%0d rssi=%0d bytes=%02h %02h %02h fin=%0b",
                     out_status, out_record_strength, out_record_byte0,
                     out_record_byte1, out_record_byte2, out_final_result);
        end else begin
          exp = deframed_q.pop_front();
          if (out_status !== exp.status || out_record_strength !== exp.rssi ||
              out_record_byte0 !== exp.b0 || out_record_byte1 !== exp.b1 ||
              out_record_byte2 !== exp.b2 || out_final_result !== exp.fin) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp st=%0d rssi=%0d bytes=%02h %02h %02h fin=%0b",
                       exp.status, exp.rssi, exp.b0, exp.b1, exp.b2, exp.fin,
                       " | got st=%0d rssi=%0d bytes=%02h %02h %02h fin=%0b",
                       out_status, out_record_strength, out_record_byte0,
                       out_record_byte1, out_record_byte2, out_final_result);
          end
        end
        nxt = draw_wait(rx_calm);
      end else if (out_stall) begin
        nxt = rx_stall_left;
      end
      if (nxt > 0) begin
        out_stall     <= 1'b1;
        rx_stall_left <= nxt - 1;
      end else begin
        out_stall     <= rx_hold;
        rx_stall_left <= 0;
      end
    end
  end

  // Long receiver hold-off during phase two: the sender keeps offering bytes,
  // the output register stays full and the block has to stall its input.
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Build one packet of the given shape and queue it byte by byte.
  // fill < 0 gives random record bytes, otherwise every record byte = fill.
  task automatic queue_packet(input pkt_kind_t kind, input int recs,
                              input logic [7:0] rssi_last, input int fill);
    logic [7:0] body[$];
    logic [7:0] v;
    logic [7:0] sum;
    rx_byte_t   it;
    int         n;
    case (kind)
      PK_LONE_LAST: begin
      end
      PK_MARKER_ONLY: begin
        body.push_back(marker);
      end
      PK_OVERFLOW: begin
        n = spd_pkg::BUFFER_BYTES + $urandom_range(1, 4);
        body.push_back(marker);
        repeat (n - 1) begin
          v = 8'($urandom_range(0, 255));
          body.push_back(v);
        end
      end
      PK_NOISE: begin
        repeat ($urandom_range(1, 8)) begin
          v = 8'($urandom_range(0, 255));
          body.push_back(v);
        end
      end
      default: begin
        v = marker;
        if (kind == PK_BAD_MARKER) v = marker ^ 8'($urandom_range(1, 255));
        body.push_back(v);
        if (kind == PK_SHORT && recs == 0) recs = 1;
        v = 8'(recs);
        body.push_back(v);
        repeat (recs * spd_pkg::RECORD_BYTES) begin
          v = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
          body.push_back(v);
        end
        // length errors: drop record bytes or append stray ones
        if (kind == PK_SHORT)
          repeat ($urandom_range(1, 2)) body.delete(body.size() - 1);
        if (kind == PK_LONG)
          repeat ($urandom_range(1, 3)) begin
            v = 8'($urandom_range(0, 255));
            body.push_back(v);
          end
      end
    endcase
    sum = '0;
    foreach (body[i]) begin
      it.data = body[i];
      it.last = 1'b0;
      it.rssi = 8'($urandom_range(0, 255));
      rx_bytes_q.push_back(it);
      sum ^= body[i];
    end
    if (kind == PK_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    if (kind == PK_NOISE) sum = 8'($urandom_range(0, 255));
    it.data = sum;
    it.last = 1'b1;
    it.rssi = rssi_last;
    rx_bytes_q.push_back(it);
    bytes_queued += body.size() + 1;
  endtask

  // Mostly well-formed packets with small record counts, the rest errors.
  task automatic random_packets(input int budget);
    int base;
    int pick;
    int recs;
    logic [7:0] rssi;
    base = bytes_queued;
    while (bytes_queued - base < budget) begin
      pick = $urandom_range(0, 99);
      recs = ($urandom_range(0, 14) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      rssi = 8'($urandom_range(0, 255));
      if (pick < 55)      queue_packet(PK_GOOD, recs, rssi, -1);
      else if (pick < 64) queue_packet(PK_BAD_SUM, recs, rssi, -1);
      else if (pick < 73) queue_packet(PK_SHORT, recs, rssi, -1);
      else if (pick < 82) queue_packet(PK_LONG, recs, rssi, -1);
      else if (pick < 88) queue_packet(PK_BAD_MARKER, recs, rssi, -1);
      else if (pick < 94) queue_packet(PK_NOISE, 0, rssi, -1);
      else if (pick < 97) queue_packet(PK_LONE_LAST, 0, rssi, -1);
      else                queue_packet(PK_MARKER_ONLY, 0, rssi, -1);
    end
  endtask

  // Sender pause: every queued byte transferred and every result back,
  // then settle quiet cycles to catch any stray result from the block.
  task automatic wait_all_done(input int settle);
    while (bytes_sent != bytes_queued || deframed_q.size() != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // Start marker write; only called while the block is idle.
  task automatic write_marker(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    marker = value;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed packets against the reset marker.
    queue_packet(PK_LONE_LAST,   0, 8'h7F, -1);    // no marker at all
    queue_packet(PK_MARKER_ONLY, 0, 8'h80, -1);    // marker but no count
    queue_packet(PK_BAD_MARKER,  0, 8'h00, -1);
    queue_packet(PK_GOOD,        0, 8'h55, -1);    // empty but fine
    queue_packet(PK_GOOD,        1, 8'h80, 8'h00); // most negative dBm
    queue_packet(PK_BAD_SUM,     1, 8'h00, 8'hFF);
    queue_packet(PK_LONG,        0, 8'h7F, -1);    // stray bytes before the checksum
    wait_all_done(SETTLE_CYCLES);

    // Phase 1: marker at zero, a sender pause halfway through.
    phase_no = 1;
    write_marker(8'h00);
    random_packets(PHASE_BYTES / 2);
    wait_all_done(SETTLE_CYCLES);
    random_packets(PHASE_BYTES / 2);
    wait_all_done(SETTLE_CYCLES);

    // Phase 2: marker at all ones, biggest good packet under the hold-off.
    write_marker(8'hFF);
    phase_no = 2;
    queue_packet(PK_GOOD, (spd_pkg::BUFFER_BYTES - 2) / spd_pkg::RECORD_BYTES,
                 8'($urandom_range(0, 255)), -1);
    random_packets(PHASE_BYTES);
    wait_all_done(SETTLE_CYCLES);

    // Phase 3: random marker and a buffer overflow.
    phase_no = 3;
    write_marker(8'($urandom_range(1, 254)));
    queue_packet(PK_OVERFLOW, 0, 8'($urandom_range(0, 255)), -1);
    random_packets(PHASE_BYTES);
    wait_all_done(END_CYCLES);

    if (n_bad == 0 && deframed_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/spd_pkg.sv
hw/rtl/spd_buf.sv
hw/rtl/sensor_packet_deframer_top.sv
tb/sensor_packet_deframer_top_tb.sv
